FILE: rtl/core/drba_pkg.sv
// shared widths and codes for the dram row buffer access block
`default_nettype none

package drba_pkg;

    localparam int ADDR_W       = 22;
    localparam int DATA_W       = 32;
    localparam int DATA_BYTES   = 4;
    localparam int CNT_W        = 3;
    localparam int LOG_WORD_MAX = 5;

    typedef logic t_func;

    localparam t_func FUNC_READ  = 1'b0;
    localparam t_func FUNC_WRITE = 1'b1;

endpackage

`default_nettype wire

FILE: rtl/core/drba_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module drba_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [0:(1 << ADDR_W)-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/dram_row_buffer_access.sv
// top level of the dram open-row buffer access block
//
// channel  direction  handshake          payload
// request  in         i_valid / o_ready  i_func, i_address, i_byte_count, i_write_data
// result   out        o_valid / i_ready  o_read_data, o_row_hit, o_wrote_back, o_crosses_row
//
// one request at a time; a row hit moves its bytes one by one through the row buffer,
// a crossing request moves none; a miss loads the row over the 32-byte port of the row
// memories, after first writing back an open row the same way
// reset clears the per-bank valid marks at once; buffered data is dropped, no write-back
// a finished result waits in the output register while the next request is taken
`default_nettype none

module dram_row_buffer_access
    import drba_pkg::*;
#(
    parameter int COLUMN_BITS = 10,
    parameter int ROW_BITS    = 8,
    parameter int BANK_BITS   = 3,
    parameter int RANK_BITS   = 1,
    parameter int MAX_BYTES   = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic              i_func,
    input  wire logic [ADDR_W-1:0] i_address,
    input  wire logic [CNT_W-1:0]  i_byte_count,
    input  wire logic [DATA_W-1:0] i_write_data,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic      [DATA_W-1:0] o_read_data,
    output logic                   o_row_hit,
    output logic                   o_wrote_back,
    output logic                   o_crosses_row
);

    localparam int BUF_BITS   = BANK_BITS + RANK_BITS;
    localparam int BUF_W      = (BUF_BITS > 0) ? BUF_BITS : 1;
    localparam int NUM_BUFS   = 1 << BUF_W;
    localparam int TOTAL_BITS = COLUMN_BITS + ROW_BITS + BUF_BITS;
    localparam int WB_BITS    = (COLUMN_BITS < LOG_WORD_MAX) ? COLUMN_BITS : LOG_WORD_MAX;
    localparam int WORD_BYTES = 1 << WB_BITS;
    localparam int WORD_W     = 8 * WORD_BYTES;
    localparam int WIDX_BITS  = COLUMN_BITS - WB_BITS;
    localparam int WIDX_W     = (WIDX_BITS > 0) ? WIDX_BITS : 1;
    localparam int NUM_WORDS  = 1 << WIDX_BITS;
    localparam int BUFRAM_AW  = BUF_W + WIDX_W;
    localparam int CELLRAM_AW = BUF_W + ROW_BITS + WIDX_W;
    localparam int EXT_W      = TOTAL_BITS + BUF_W + ADDR_W;

    localparam logic [CNT_W-1:0] CNT_LIMIT =
        CNT_W'((MAX_BYTES < DATA_BYTES) ? MAX_BYTES : DATA_BYTES);
    localparam logic [COLUMN_BITS:0] ROW_LEN  = {1'b1, {COLUMN_BITS{1'b0}}};
    localparam logic [BUF_W-1:0]     BUF_MASK = BUF_W'((1 << BUF_BITS) - 1);
    localparam logic [WIDX_BITS:0]   K_END    = (WIDX_BITS + 1)'(NUM_WORDS);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOOKUP = 3'd1;
    localparam logic [2:0] S_WBACK  = 3'd2;
    localparam logic [2:0] S_LOAD   = 3'd3;
    localparam logic [2:0] S_ACC_RD = 3'd4;
    localparam logic [2:0] S_ACC_WR = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]             r_state;
    logic [2:0]             n_state;
    t_func                  r_func;
    logic [COLUMN_BITS-1:0] r_col;
    logic [ROW_BITS-1:0]    r_row;
    logic [ROW_BITS-1:0]    r_old_row;
    logic [BUF_W-1:0]       r_buf;
    logic [CNT_W-1:0]       r_cnt;
    logic [CNT_W-1:0]       r_i;
    logic [DATA_W-1:0]      r_wdata;
    logic [DATA_W-1:0]      r_rdata;
    logic                   r_cross;
    logic                   r_hit;
    logic                   r_back;
    logic [WIDX_BITS:0]     r_k;
    logic                   r_cp_v;
    logic [WIDX_W-1:0]      r_cp_k;
    logic [NUM_BUFS-1:0]    r_valid;
    logic                   r_out_valid;
    logic [DATA_W-1:0]      r_out_rdata;
    logic                   r_out_hit;
    logic                   r_out_back;
    logic                   r_out_cross;

    logic [EXT_W-1:0]       in_ext;
    logic [COLUMN_BITS-1:0] in_col;
    logic [BUF_W-1:0]       in_buf;
    logic [CNT_W-1:0]       in_cnt;
    logic                   in_cross;
    logic                   accept;
    logic                   out_load;
    logic                   k_done;
    logic                   hit_now;
    logic [COLUMN_BITS-1:0] pos;
    logic [WIDX_W-1:0]      acc_widx;
    logic [WB_BITS-1:0]     acc_off;
    logic [WORD_W-1:0]      merged;

    logic                   buf_we;
    logic [BUFRAM_AW-1:0]   buf_waddr;
    logic [BUFRAM_AW-1:0]   buf_raddr;
    logic [WORD_W-1:0]      buf_wdata;
    logic [WORD_W-1:0]      buf_rdata;
    logic                   cell_we;
    logic [CELLRAM_AW-1:0]  cell_waddr;
    logic [CELLRAM_AW-1:0]  cell_raddr;
    logic [WORD_W-1:0]      cell_rdata;
    logic                   tag_we;
    logic [ROW_BITS-1:0]    tag_rdata;

    // request decode
    assign in_ext   = EXT_W'(i_address);
    assign in_col   = in_ext[COLUMN_BITS-1:0];
    assign in_buf   = in_ext[COLUMN_BITS+ROW_BITS +: BUF_W] & BUF_MASK;
    assign in_cnt   = (i_byte_count > CNT_LIMIT) ? CNT_LIMIT : i_byte_count;
    assign in_cross = ({1'b0, in_col} + (COLUMN_BITS + 1)'(in_cnt)) > ROW_LEN;

    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign out_load = (r_state == S_DONE) && (!r_out_valid || i_ready);
    assign k_done   = (r_k == K_END);
    assign hit_now  = r_valid[r_buf] && (tag_rdata == r_row);

    assign pos      = r_col + COLUMN_BITS'(r_i);
    assign acc_widx = WIDX_W'(pos >> WB_BITS);
    assign acc_off  = pos[WB_BITS-1:0];

    // byte merge for a write beat into the buffer word
    always_comb begin
        for (int j = 0; j < WORD_BYTES; j++) begin
            if (WB_BITS'(j) == acc_off) begin
                merged[8*j +: 8] = r_wdata[{r_i[1:0], 3'b000} +: 8];
            end else begin
                merged[8*j +: 8] = buf_rdata[8*j +: 8];
            end
        end
    end

    // row buffer ports
    assign buf_raddr = (r_state == S_WBACK) ? {r_buf, r_k[WIDX_W-1:0]} : {r_buf, acc_widx};
    assign buf_we    = ((r_state == S_LOAD) && r_cp_v)
                    || ((r_state == S_ACC_WR) && (r_func == FUNC_WRITE));
    assign buf_waddr = (r_state == S_LOAD) ? {r_buf, r_cp_k} : {r_buf, acc_widx};
    assign buf_wdata = (r_state == S_LOAD) ? cell_rdata : merged;

    // cell array ports
    assign cell_raddr = {r_buf, r_row, r_k[WIDX_W-1:0]};
    assign cell_we    = (r_state == S_WBACK) && r_cp_v;
    assign cell_waddr = {r_buf, r_old_row, r_cp_k};

    assign tag_we = (r_state == S_LOOKUP) && !r_cross && !hit_now;

    drba_ram #(
        .DATA_W (WORD_W),
        .ADDR_W (BUFRAM_AW)
    ) u_row_buf (
        .i_clk   (i_clk),
        .i_we    (buf_we),
        .i_waddr (buf_waddr),
        .i_wdata (buf_wdata),
        .i_raddr (buf_raddr),
        .o_rdata (buf_rdata)
    );

    drba_ram #(
        .DATA_W (WORD_W),
        .ADDR_W (CELLRAM_AW)
    ) u_cell_array (
        .i_clk   (i_clk),
        .i_we    (cell_we),
        .i_waddr (cell_waddr),
        .i_wdata (buf_rdata),
        .i_raddr (cell_raddr),
        .o_rdata (cell_rdata)
    );

    drba_ram #(
        .DATA_W (ROW_BITS),
        .ADDR_W (BUF_W)
    ) u_open_tag (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_waddr (r_buf),
        .i_wdata (r_row),
        .i_raddr (in_buf),
        .o_rdata (tag_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                if (r_cross) begin
                    n_state = S_DONE;
                end else if (hit_now) begin
                    n_state = S_ACC_RD;
                end else if (r_valid[r_buf]) begin
                    n_state = S_WBACK;
                end else begin
                    n_state = S_LOAD;
                end
            end
            S_WBACK: begin
                if (k_done) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (k_done) begin
                    n_state = S_ACC_RD;
                end
            end
            S_ACC_RD: begin
                n_state = (r_i == r_cnt) ? S_DONE : S_ACC_WR;
            end
            S_ACC_WR: begin
                n_state = S_ACC_RD;
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_cp_v      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (tag_we) begin
                r_valid[r_buf] <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (accept) begin
                r_cp_v <= 1'b0;
            end else if ((r_state == S_WBACK) || (r_state == S_LOAD)) begin
                r_cp_v <= !k_done;
            end
        end
    end

    // request and datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func  <= i_func;
            r_col   <= in_col;
            r_row   <= in_ext[COLUMN_BITS +: ROW_BITS];
            r_buf   <= in_buf;
            r_cnt   <= in_cnt;
            r_wdata <= i_write_data;
            r_cross <= in_cross;
            r_rdata <= '0;
            r_i     <= '0;
            r_k     <= '0;
        end
        if (r_state == S_LOOKUP) begin
            r_hit     <= !r_cross && hit_now;
            r_back    <= !r_cross && !hit_now && r_valid[r_buf];
            r_old_row <= tag_rdata;
        end
        if ((r_state == S_WBACK) || (r_state == S_LOAD)) begin
            r_cp_k <= r_k[WIDX_W-1:0];
            r_k    <= k_done ? '0 : r_k + 1'b1;
        end
        if (r_state == S_ACC_WR) begin
            if (r_func == FUNC_READ) begin
                r_rdata[{r_i[1:0], 3'b000} +: 8] <= buf_rdata[{acc_off, 3'b000} +: 8];
            end
            r_i <= r_i + 1'b1;
        end
        if (out_load) begin
            r_out_rdata <= r_rdata;
            r_out_hit   <= r_hit;
            r_out_back  <= r_back;
            r_out_cross <= r_cross;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_read_data   = r_out_rdata;
    assign o_row_hit     = r_out_hit;
    assign o_wrote_back  = r_out_back;
    assign o_crosses_row = r_out_cross;

endmodule

`default_nettype wire

FILE: rtl/core/drba_checker.sv
// port-level checks for the dram row buffer access block, bound to the top level
`default_nettype none

module drba_checker
    import drba_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_valid,
    input wire logic              o_ready,
    input wire logic              o_valid,
    input wire logic              i_ready,
    input wire logic [DATA_W-1:0] o_read_data,
    input wire logic              o_row_hit,
    input wire logic              o_wrote_back,
    input wire logic              o_crosses_row
);

    // no result beat right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // a crossing request opens nothing and moves no byte
    a_cross_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_crosses_row |-> (o_read_data == '0) && !o_row_hit && !o_wrote_back)
        else $error("crossing result carries data or flags");

    // a hit never writes back
    a_hit_no_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_row_hit && o_wrote_back))
        else $error("hit and write-back together");

    // one request at a time: busy in the cycle after a request beat
    a_one_at_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("request taken back to back");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_read_data) && $stable(o_row_hit)
            && $stable(o_wrote_back) && $stable(o_crosses_row))
        else $error("stalled result changed");

endmodule

bind dram_row_buffer_access drba_checker u_drba_checker (.*);

`default_nettype wire

FILE: tb/testbench.sv
// self-checking testbench for the dram open-row buffer access block
`timescale 1ns / 1ps

module testbench
    import drba_pkg::*;
();

    localparam int COLUMN_BITS  = 10;
    localparam int ROW_BITS     = 8;
    localparam int BANK_BITS    = 3;
    localparam int RANK_BITS    = 1;
    localparam int MAX_BYTES    = 4;
    localparam int BUF_BITS     = BANK_BITS + RANK_BITS;
    localparam int ROW_LEN      = 1 << COLUMN_BITS;
    localparam int NUM_ROWS     = 1 << ROW_BITS;
    localparam int NUM_BUFS     = 1 << BUF_BITS;
    localparam int BYTE_LIMIT   = (MAX_BYTES < DATA_BYTES) ? MAX_BYTES : DATA_BYTES;
    localparam int DRAIN_CYCLES = 200;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef enum int {STALL_NONE, STALL_SHORT, STALL_LONG} t_stall_mode;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              row_hit;
        logic              wrote_back;
        logic              crosses_row;
    } t_access_outcome;

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              i_valid      = 1'b0;
    logic              o_ready;
    logic              i_func       = FUNC_READ;
    logic [ADDR_W-1:0] i_address    = '0;
    logic [CNT_W-1:0]  i_byte_count = '0;
    logic [DATA_W-1:0] i_write_data = '0;
    logic              o_valid;
    logic              i_ready      = 1'b0;
    logic [DATA_W-1:0] o_read_data;
    logic              o_row_hit;
    logic              o_wrote_back;
    logic              o_crosses_row;

    // predictor state: only bytes that hold written data have entries
    logic [7:0]  cell_bytes[int unsigned];
    logic [7:0]  page_bytes[int unsigned];
    int unsigned open_row[NUM_BUFS];
    bit          bank_open[NUM_BUFS];

    t_access_outcome   pending_outcomes[$];
    t_access_outcome   want;
    logic [ADDR_W-1:0] written_addrs[$];
    int unsigned       error_count = 0;
    int unsigned       cycle_count = 0;
    bit                sender_idles = 1'b0;
    int unsigned       burst_left = 0;
    t_stall_mode       stall_mode = STALL_NONE;
    int unsigned       stall_left = 0;

    dram_row_buffer_access #(
        .COLUMN_BITS(COLUMN_BITS),
        .ROW_BITS(ROW_BITS),
        .BANK_BITS(BANK_BITS),
        .RANK_BITS(RANK_BITS),
        .MAX_BYTES(MAX_BYTES)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_func(i_func),
        .i_address(i_address),
        .i_byte_count(i_byte_count),
        .i_write_data(i_write_data),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_read_data(o_read_data),
        .o_row_hit(o_row_hit),
        .o_wrote_back(o_wrote_back),
        .o_crosses_row(o_crosses_row)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [ADDR_W-1:0] make_addr(int unsigned bank, int unsigned row,
                                                    int unsigned col);
        return ADDR_W'(((bank * NUM_ROWS + row) * ROW_LEN) + col);
    endfunction

    // bytes from addr upward that hold written data in the copy the access will see
    function automatic int unsigned bytes_known(logic [ADDR_W-1:0] addr, int unsigned n);
        int unsigned col, row, bank, k;
        bit in_page;
        col = addr[COLUMN_BITS-1:0];
        row = addr[COLUMN_BITS +: ROW_BITS];
        bank = addr[COLUMN_BITS+ROW_BITS +: BUF_BITS];
        in_page = bank_open[bank] && open_row[bank] == row;
        k = 0;
        while (k < n && (in_page ? page_bytes.exists(bank * ROW_LEN + col + k)
                                 : cell_bytes.exists(int'(addr) + k)))
            k++;
        return k;
    endfunction

    function automatic t_access_outcome open_row_access(t_func func, logic [ADDR_W-1:0] addr,
                                                        logic [CNT_W-1:0] cnt,
                                                        logic [DATA_W-1:0] wdata);
        t_access_outcome res;
        int unsigned col, row, bank, n, page_base, old_base, new_base, c;
        res = '0;
        col = addr[COLUMN_BITS-1:0];
        row = addr[COLUMN_BITS +: ROW_BITS];
        bank = addr[COLUMN_BITS+ROW_BITS +: BUF_BITS];
        n = (cnt > BYTE_LIMIT) ? BYTE_LIMIT : cnt;
        page_base = bank * ROW_LEN;
        new_base = int'(addr) - col;
        if (col + n > ROW_LEN) begin
            res.crosses_row = 1'b1;
        end else begin
            if (bank_open[bank] && open_row[bank] == row) begin
                res.row_hit = 1'b1;
            end else begin
                if (bank_open[bank]) begin
                    old_base = (bank * NUM_ROWS + open_row[bank]) * ROW_LEN;
                    for (c = 0; c < ROW_LEN; c++)
                        if (page_bytes.exists(page_base + c))
                            cell_bytes[old_base + c] = page_bytes[page_base + c];
                    res.wrote_back = 1'b1;
                end
                for (c = 0; c < ROW_LEN; c++)
                    if (cell_bytes.exists(new_base + c))
                        page_bytes[page_base + c] = cell_bytes[new_base + c];
                    else
                        page_bytes.delete(page_base + c);
                open_row[bank] = row;
                bank_open[bank] = 1'b1;
            end
            for (c = 0; c < n; c++)
                if (func == FUNC_WRITE)
                    page_bytes[page_base + col + c] = wdata[8*c +: 8];
                else
                    res.read_data[8*c +: 8] = page_bytes[page_base + col + c];
        end
        return res;
    endfunction

    task automatic send_access(input t_func func, input logic [ADDR_W-1:0] addr,
                               input logic [CNT_W-1:0] cnt, input logic [DATA_W-1:0] wdata);
        int unsigned n, known, gap;
        bit crosses;
        n = (cnt > BYTE_LIMIT) ? BYTE_LIMIT : cnt;
        crosses = addr[COLUMN_BITS-1:0] + n > ROW_LEN;
        // reads only touch bytes that were written
        if (func == FUNC_READ && !crosses && n != 0) begin
            known = bytes_known(addr, n);
            if (known == 0)
                func = FUNC_WRITE;
            else if (known < n)
                cnt = known[CNT_W-1:0];
        end
        gap = 0;
        if (sender_idles) begin
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 90)
                                                  : $urandom_range(1, 5);
                burst_left = $urandom_range(1, 12);
            end else begin
                burst_left--;
            end
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= func;
        i_address <= addr;
        i_byte_count <= cnt;
        i_write_data <= wdata;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_outcomes.push_back(open_row_access(func, addr, cnt, wdata));
        if (func == FUNC_WRITE && !crosses && n != 0)
            written_addrs.push_back(addr);
    endtask

    task automatic run_random(int unsigned items, int unsigned bank_top, int unsigned hot_rows);
        int unsigned kind, bank, row, col;
        logic [CNT_W-1:0] cnt;
        logic [ADDR_W-1:0] addr;
        t_func func;
        for (int unsigned i = 0; i < items; i++) begin
            kind = $urandom_range(0, 99);
            bank = $urandom_range(0, bank_top);
            row = ($urandom_range(0, 9) == 0) ? $urandom_range(0, NUM_ROWS - 1)
                                               : $urandom_range(0, hot_rows - 1);
            col = ($urandom_range(0, 7) == 0) ? $urandom_range(ROW_LEN - 4, ROW_LEN - 1)
                                              : $urandom_range(0, ROW_LEN - 1);
            cnt = CNT_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 7)
                                                     : $urandom_range(1, BYTE_LIMIT));
            func = FUNC_WRITE;
            addr = make_addr(bank, row, col);
            if (kind >= 45 && kind < 90) begin
                func = FUNC_READ;
                addr = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
            end else if (kind >= 90) begin
                func = $urandom_range(0, 1) ? FUNC_WRITE : FUNC_READ;
                addr = ADDR_W'($urandom_range(0, (1 << ADDR_W) - 1));
            end
            send_access(func, addr, cnt, $urandom);
        end
    endtask

    task automatic test_corner_accesses;
        sender_idles = 1'b0;
        stall_mode = STALL_SHORT;
        send_access(FUNC_WRITE, make_addr(0, 0, 0), 4, 32'h0403_0201);
        send_access(FUNC_READ, make_addr(0, 0, 0), 4, '0);
        send_access(FUNC_WRITE, make_addr(0, 0, ROW_LEN - 1), 1, 32'hFFFF_FF5A);
        send_access(FUNC_READ, make_addr(0, 0, ROW_LEN - 1), 1, 32'hFFFF_FFFF);
        send_access(FUNC_WRITE, make_addr(0, 0, ROW_LEN - 3), 4, 32'hDEAD_BEEF);
        send_access(FUNC_READ, make_addr(0, 0, ROW_LEN - 1), 2, '0);
        send_access(FUNC_WRITE, make_addr(0, 1, 5), 0, 32'hFFFF_FFFF);
        send_access(FUNC_READ, make_addr(0, 0, 0), 4, '0);
        send_access(FUNC_READ, make_addr(0, 0, 1), 3, '0);
        send_access(FUNC_WRITE, make_addr(NUM_BUFS - 1, NUM_ROWS - 1, 256), 7, 32'hFFFF_FFFF);
        send_access(FUNC_READ, make_addr(NUM_BUFS - 1, NUM_ROWS - 1, 256), 5, '0);
        send_access(FUNC_READ, make_addr(NUM_BUFS - 1, NUM_ROWS - 1, 256), 6, '0);
        send_access(FUNC_READ, make_addr(NUM_BUFS - 1, NUM_ROWS - 1, 257), 7, '0);
        send_access(FUNC_WRITE, make_addr(NUM_BUFS - 1, NUM_ROWS - 1, ROW_LEN - 1), 1,
                    32'h0000_00A5);
        send_access(FUNC_READ, make_addr(NUM_BUFS - 1, NUM_ROWS - 1, ROW_LEN - 1), 1, '0);
        send_access(FUNC_READ, make_addr(3, 7, 100), 0, 32'hFFFF_FFFF);
        send_access(FUNC_WRITE, make_addr(NUM_BUFS - 1, NUM_ROWS - 1, ROW_LEN - 2), 2,
                    32'h1234_C3C3);
        send_access(FUNC_WRITE, make_addr(NUM_BUFS - 1, NUM_ROWS - 1, ROW_LEN - 2), 3,
                    32'h8765_4321);
        send_access(FUNC_WRITE, make_addr(NUM_BUFS - 1, NUM_ROWS - 1, 256), 2, 32'h5555_0000);
        send_access(FUNC_READ, make_addr(NUM_BUFS - 1, NUM_ROWS - 1, 256), 4, '0);
        send_access(FUNC_WRITE, make_addr(NUM_BUFS - 1, 0, 256), 4, 32'h0F0F_0F0F);
        send_access(FUNC_READ, make_addr(NUM_BUFS - 1, NUM_ROWS - 1, ROW_LEN - 2), 2, '0);
    endtask

    // few banks and rows so that most misses evict an open row
    task automatic test_bank_conflicts;
        sender_idles = 1'b1;
        stall_mode = STALL_SHORT;
        run_random(120, 1, 3);
    endtask

    task automatic test_mixed_traffic;
        sender_idles = 1'b1;
        stall_mode = STALL_LONG;
        run_random(220, NUM_BUFS - 1, 4);
    endtask

    task automatic test_streaming;
        sender_idles = 1'b0;
        stall_mode = STALL_NONE;
        run_random(110, NUM_BUFS - 1, 2);
    endtask

    // receiver stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n || stall_mode == STALL_NONE) begin
            i_ready <= 1'b1;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            i_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            i_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                stall_left <= (stall_mode == STALL_SHORT) ? $urandom_range(1, 3)
                                                          : $urandom_range(5, 60);
        end
    end

    // result beat checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_outcomes.size() == 0) begin
                $display("%0t: unexpected result beat, read_data %h", $time, o_read_data);
                error_count++;
            end else begin
                want = pending_outcomes.pop_front();
                if (o_read_data !== want.read_data) begin
                    $display("%0t: read_data expected %h got %h", $time, want.read_data,
                             o_read_data);
                    error_count++;
                end
                if (o_row_hit !== want.row_hit) begin
                    $display("%0t: row_hit expected %b got %b", $time, want.row_hit,
                             o_row_hit);
                    error_count++;
                end
                if (o_wrote_back !== want.wrote_back) begin
                    $display("%0t: wrote_back expected %b got %b", $time, want.wrote_back,
                             o_wrote_back);
                    error_count++;
                end
                if (o_crosses_row !== want.crosses_row) begin
                    $display("%0t: crosses_row expected %b got %b", $time, want.crosses_row,
                             o_crosses_row);
                    error_count++;
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL dram_row_buffer_access");
        $finish;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_corner_accesses();
        test_bank_conflicts();
        test_mixed_traffic();
        test_streaming();
        i_valid <= 1'b0;
        stall_mode = STALL_NONE;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("PASS dram_row_buffer_access");
        else
            $display("FAIL dram_row_buffer_access");
        $finish;
    end

endmodule

FILE: dram_row_buffer_access.f
rtl/core/drba_pkg.sv
rtl/core/drba_ram.sv
rtl/core/dram_row_buffer_access.sv
rtl/core/drba_checker.sv
tb/testbench.sv
